>>> hw/rtl/hdu_pkg.sv
// ----------------------------------------------------------------------------
// hdu_pkg
// Types and constants shared by the half-duplex 8N1 serial port.
// ----------------------------------------------------------------------------
package hdu_pkg;

	// Widths of the payload fields
	localparam int unsigned KindW   = 2;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned ModeW   = 3;
	localparam int unsigned CntW    = 4;
	localparam int unsigned InDataW  = 16;
	localparam int unsigned OutDataW = 16;

	// Register indexes on the configuration port
	localparam logic REG_BIT_PERIOD   = 1'b0;
	localparam logic REG_FIRST_SAMPLE = 1'b1;

	// Register reset values
	localparam logic [ByteW-1:0] BitPeriodRst   = 8'd104;
	localparam logic [ByteW-1:0] FirstSampleRst = 8'd147;

	// Data bits per frame
	localparam logic [CntW-1:0] DataBits = 4'd8;

	// Input beat kinds
	typedef enum logic [KindW-1:0] {
		KIND_TICK = 2'd0,
		KIND_SEND = 2'd1,
		KIND_TAKE = 2'd2
	} kind_t;

	// Port phase, also reported as mode
	typedef enum logic [ModeW-1:0] {
		PH_IDLE = 3'd0,
		PH_TX   = 3'd1,
		PH_STOP = 3'd2,
		PH_RX   = 3'd3,
		PH_PEND = 3'd4
	} phase_t;

	// One input item
	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [ByteW-1:0] tx_byte;
		logic             rx_level;
	} item_t;

	// One result item
	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic             accepted;
		logic             data_ready;
		logic [ByteW-1:0] rx_byte;
		logic             tx_level;
	} result_t;

endpackage

>>> hw/rtl/half_duplex_uart_top.sv
// Half-duplex 8N1 serial port. Every input beat is one item (a baud tick, a
// send request or a take of the received byte) and produces exactly one result
// beat showing the port state after that item. The block takes one item per
// clock cycle while the result side is not stalled; each item passes the input
// register, the combinational next-state logic and the result register before
// its result is valid. A stalled result register holds the input side only
// while the input register is full. The user must write configuration on the
// cfg port only while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
// half_duplex_uart_top
// Input register, port core and result register with stream handshakes.
// ----------------------------------------------------------------------------
module half_duplex_uart_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [hdu_pkg::ByteW-1:0]       cfg_data,
	// Input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hdu_pkg::InDataW-1:0]     s_tdata,  // tx_byte[7:0], rx_level[8], zero fill
	input  logic [hdu_pkg::KindW-1:0]       s_tuser,  // kind[1:0]
	// Result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hdu_pkg::OutDataW-1:0]    m_tdata   // tx_level[0], rx_byte[8:1],
	                                                  // data_ready[9], accepted[10],
	                                                  // mode[13:11], zero fill
);
	import hdu_pkg::*;

	logic    valid_s1, valid_s2;
	item_t   item_s1;
	result_t res, res_s2;
	logic    advance;

	// Stage 1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind     <= s_tuser;
			item_s1.tx_byte  <= s_tdata[ByteW-1:0];
			item_s1.rx_level <= s_tdata[ByteW];
		end
	end

	hdu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (advance),
		.item      (item_s1),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_s2};

endmodule

>>> hw/rtl/hdu_core.sv
// ----------------------------------------------------------------------------
// hdu_core
// Port state, configuration registers and the combinational next-state logic.
// The result reflects the state after the item.
// ----------------------------------------------------------------------------
module hdu_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [hdu_pkg::ByteW-1:0]     cfg_data,
	input  logic                          fire,
	input  hdu_pkg::item_t                item,
	output hdu_pkg::result_t              res
);
	import hdu_pkg::*;

	logic [ByteW-1:0] bit_period_q, first_sample_q;
	phase_t           phase_q, phase_d;
	logic [ByteW-1:0] tick_q, tick_d;
	logic [ByteW-1:0] tx_shift_q, tx_shift_d;
	logic [CntW-1:0]  tx_bits_q, tx_bits_d;
	logic [ByteW-1:0] rx_shift_q, rx_shift_d;
	logic [CntW-1:0]  rx_bits_q, rx_bits_d;
	logic             line_q, line_d;
	logic             prev_rx_q, prev_rx_d;
	logic             acc;

	logic [ByteW-1:0] period, last, tick_inc;
	logic             expire, fall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q   <= BitPeriodRst;
			first_sample_q <= FirstSampleRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BIT_PERIOD:   bit_period_q   <= cfg_data;
				REG_FIRST_SAMPLE: first_sample_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Period timer: a value of zero wraps and acts as 256 ticks
	always_comb begin
		period   = (phase_q == PH_RX && rx_bits_q == '0) ? first_sample_q : bit_period_q;
		last     = period - 8'd1;
		expire   = (tick_q == last);
		tick_inc = expire ? '0 : tick_q + 8'd1;
		fall     = prev_rx_q && !item.rx_level;
	end

	// Next state
	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		tx_shift_d = tx_shift_q;
		tx_bits_d  = tx_bits_q;
		rx_shift_d = rx_shift_q;
		rx_bits_d  = rx_bits_q;
		line_d     = line_q;
		prev_rx_d  = prev_rx_q;
		acc        = 1'b0;
		unique case (item.kind)
			KIND_TICK: begin
				unique case (phase_q)
					PH_IDLE, PH_PEND: ;
					PH_TX: begin
						tick_d = tick_inc;
						if (expire) begin
							if (tx_bits_q < DataBits) begin
								line_d     = tx_shift_q[0];
								tx_shift_d = {1'b0, tx_shift_q[ByteW-1:1]};
								tx_bits_d  = tx_bits_q + 4'd1;
							end else begin
								line_d  = 1'b1;
								phase_d = PH_STOP;
							end
						end
					end
					PH_STOP: begin
						tick_d = tick_inc;
						if (expire)
							phase_d = PH_IDLE;
					end
					PH_RX: begin
						tick_d = tick_inc;
						if (expire) begin
							if (rx_bits_q < DataBits) begin
								rx_bits_d  = rx_bits_q + 4'd1;
								rx_shift_d = {item.rx_level, rx_shift_q[ByteW-1:1]};
							end else begin
								phase_d = PH_PEND;
							end
						end
					end
					default: phase_d = PH_IDLE;
				endcase
				// Falling edge outside reception restarts the receiver
				if (fall && phase_q != PH_RX) begin
					phase_d   = PH_RX;
					tick_d    = '0;
					rx_bits_d = '0;
					line_d    = 1'b1;
				end
				prev_rx_d = item.rx_level;
			end
			KIND_SEND: begin
				if (phase_q == PH_IDLE) begin
					phase_d    = PH_TX;
					tx_shift_d = item.tx_byte;
					tx_bits_d  = '0;
					tick_d     = '0;
					line_d     = 1'b0;
					acc        = 1'b1;
				end
			end
			KIND_TAKE: begin
				if (phase_q == PH_PEND)
					phase_d = PH_IDLE;
			end
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_q     <= '0;
			tx_shift_q <= '0;
			tx_bits_q  <= '0;
			rx_shift_q <= '0;
			rx_bits_q  <= '0;
			line_q     <= 1'b1;
			prev_rx_q  <= 1'b1;
		end else if (fire) begin
			phase_q    <= phase_d;
			tick_q     <= tick_d;
			tx_shift_q <= tx_shift_d;
			tx_bits_q  <= tx_bits_d;
			rx_shift_q <= rx_shift_d;
			rx_bits_q  <= rx_bits_d;
			line_q     <= line_d;
			prev_rx_q  <= prev_rx_d;
		end
	end

	// Result after this item
	always_comb begin
		res.tx_level   = line_d;
		res.rx_byte    = rx_shift_d;
		res.data_ready = (phase_d == PH_PEND);
		res.accepted   = acc;
		res.mode       = phase_d;
	end

	// Checks
	a_accept_starts_tx: assert property (@(posedge clk) disable iff (!arst_n)
		fire && acc |=> phase_q == PH_TX && !line_q && tx_bits_q == '0)
		else $error("accepted send did not start a frame");
	a_tx_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		tx_bits_q <= DataBits)
		else $error("transmit bit count out of range");
	a_rx_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		rx_bits_q <= DataBits)
		else $error("receive bit count out of range");
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(tick_q) && $stable(prev_rx_q))
		else $error("state moved without an item");

endmodule
